// File: sv/sis_pkg.sv
// Package for the sorted interval set: widths, codes, state encoding and
// the control and flag bundles shared by the cell row and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sis_pkg;

    localparam int MAX_RANGES = 16;
    localparam int TIME_BITS  = 48;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    typedef logic signed [TIME_BITS-1:0] time_t;
    typedef logic [IDX_W-1:0]            idx_t;
    typedef logic [CNT_W-1:0]            cnt_t;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_CONTAINS = 2'd1,
        CMD_NEAREST  = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the row.
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_WRITE = 2'd1,
        OP_UP    = 2'd2,
        OP_DN    = 2'd3
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_CMP  = 3'd1,
        S_EVAL = 3'd2,
        S_NEAR = 3'd3,
        S_WR   = 3'd4,
        S_DN   = 3'd5,
        S_RESP = 3'd6
    } state_t;

    typedef struct packed {
        cell_op_t op;
        cnt_t     lb;
        cnt_t     used;
        time_t    ta;
        time_t    tb;
        time_t    nlo;
        time_t    nhi;
    } cell_ctl_t;

    typedef struct packed {
        logic reach;
        logic merge;
        logic contain;
    } cell_flags_t;

endpackage
`default_nettype wire

// File: sv/sis_if.sv
// Handshake interfaces for the request and response channels of the
// sorted interval set. Depends on sis_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface sis_req_if;
    import sis_pkg::*;
    logic  valid;
    logic  ready;
    cmd_t  cmd;
    time_t time_a;
    time_t time_b;
    idx_t  slot;
    modport source (output valid, cmd, time_a, time_b, slot, input ready);
    modport sink (input valid, cmd, time_a, time_b, slot, output ready);
endinterface

interface sis_rsp_if;
    import sis_pkg::*;
    logic    valid;
    logic    ready;
    status_t status;
    logic    hit;
    time_t   value;
    time_t   value_end;
    cnt_t    count;
    modport source (output valid, status, hit, value, value_end, count, input ready);
    modport sink (input valid, status, hit, value, value_end, count, output ready);
endinterface
`default_nettype wire

// File: sv/sorted_interval_set.sv
// Top level of the sorted interval set: the row of range cells and the
// sequencer that evaluates commands and shifts the row.
// Depends on sis_pkg, sis_if and sis_cell.
//
//  Channel | Direction | Fields
//  req     | in        | cmd, time_a, time_b, slot
//  rsp     | out       | status, hit, value, value_end, count
//
// Contains and read pass through S_CMP and S_EVAL to the result register,
// nearest also through S_NEAR when the point lies between two ranges. An
// add that fits goes on to S_WR, then takes one S_DN step for each merged
// range beyond the first, each one shift of the cell row towards lower
// slots. One item is in work at a time. Reset empties the set at once.
// A result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module sorted_interval_set (
    input  wire       clk,
    input  wire       rst_n,
    sis_req_if.sink   req,
    sis_rsp_if.source rsp
);
    import sis_pkg::*;

    state_t  state_reg, state_next;
    cmd_t    cmd_reg, cmd_next;
    time_t   ta_reg, ta_next;
    time_t   tb_reg, tb_next;
    idx_t    slot_reg, slot_next;
    cnt_t    used_reg, used_next;
    cnt_t    lb_reg, lb_next;
    cnt_t    k_reg, k_next;
    cnt_t    dn_left_reg, dn_left_next;
    time_t   nlo_reg, nlo_next;
    time_t   nhi_reg, nhi_next;
    time_t   prev_reg, prev_next;
    time_t   near_reg, near_next;
    status_t res_status_reg, res_status_next;
    logic    res_hit_reg, res_hit_next;
    time_t   res_value_reg, res_value_next;
    time_t   res_end_reg, res_end_next;
    logic    out_valid_reg, out_valid_next;
    status_t out_status_reg, out_status_next;
    logic    out_hit_reg, out_hit_next;
    time_t   out_value_reg, out_value_next;
    time_t   out_end_reg, out_end_next;
    cnt_t    out_count_reg, out_count_next;

    cell_ctl_t   ctl;
    cell_op_t    op;
    time_t       lo_arr [MAX_RANGES];
    time_t       hi_arr [MAX_RANGES];
    cell_flags_t flags_arr [MAX_RANGES];
    logic [MAX_RANGES-1:0] reach_vec, merge_vec, contain_vec;

    cnt_t                lb_c, k_c, end_c;
    logic [CNT_W:0]      newcnt_c;
    logic [TIME_BITS:0]  d_prev, d_next;

    // Row of cells, each linked to its neighbours.
    assign ctl = '{op: op, lb: lb_reg, used: used_reg, ta: ta_reg, tb: tb_reg,
                   nlo: nlo_reg, nhi: nhi_reg};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RANGES; gi++)
        begin : g_cell
            sis_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .idx      (IDX_W'(gi)),
                .ctl      (ctl),
                .below_lo (lo_arr[(gi == 0) ? 0 : gi - 1]),
                .below_hi (hi_arr[(gi == 0) ? 0 : gi - 1]),
                .above_lo (lo_arr[(gi == MAX_RANGES - 1) ? gi : gi + 1]),
                .above_hi (hi_arr[(gi == MAX_RANGES - 1) ? gi : gi + 1]),
                .lo       (lo_arr[gi]),
                .hi       (hi_arr[gi]),
                .flags    (flags_arr[gi])
            );
            assign reach_vec[gi]   = flags_arr[gi].reach;
            assign merge_vec[gi]   = flags_arr[gi].merge;
            assign contain_vec[gi] = flags_arr[gi].contain;
        end
    endgenerate

    // First reaching slot and the number of ranges the new one absorbs.
    always_comb
    begin
        lb_c = used_reg;
        k_c  = '0;
        for (int i = MAX_RANGES - 1; i >= 0; i--)
        begin
            if (reach_vec[i])
                lb_c = CNT_W'(i);
        end
        for (int i = 0; i < MAX_RANGES; i++)
            k_c = k_c + CNT_W'(merge_vec[i]);
        end_c    = lb_c + k_c - CNT_W'(1);
        newcnt_c = {1'b0, used_reg} + (CNT_W+1)'(1) - {1'b0, k_c};
    end

    // Distances to the previous range end and the next range start.
    assign d_prev = {ta_reg[TIME_BITS-1], ta_reg} - {prev_reg[TIME_BITS-1], prev_reg};
    assign d_next = {near_reg[TIME_BITS-1], near_reg} - {ta_reg[TIME_BITS-1], ta_reg};

    // Sequencer: next state, cell operation and result values.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        ta_next         = ta_reg;
        tb_next         = tb_reg;
        slot_next       = slot_reg;
        used_next       = used_reg;
        lb_next         = lb_reg;
        k_next          = k_reg;
        dn_left_next    = dn_left_reg;
        nlo_next        = nlo_reg;
        nhi_next        = nhi_reg;
        prev_next       = prev_reg;
        near_next       = near_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        res_value_next  = res_value_reg;
        res_end_next    = res_end_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_hit_next    = out_hit_reg;
        out_value_next  = out_value_reg;
        out_end_next    = out_end_reg;
        out_count_next  = out_count_reg;
        op              = OP_HOLD;
        req.ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    ta_next    = req.time_a;
                    tb_next    = req.time_b;
                    slot_next  = req.slot;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                res_status_next = ST_OK;
                res_hit_next    = 1'b0;
                res_value_next  = '0;
                res_end_next    = '0;
                lb_next         = lb_c;
                k_next          = k_c;
                nlo_next        = ta_reg;
                nhi_next        = tb_reg;
                if (k_c != '0 && lo_arr[lb_c[IDX_W-1:0]] < ta_reg)
                    nlo_next = lo_arr[lb_c[IDX_W-1:0]];
                if (k_c != '0 && tb_reg < hi_arr[end_c[IDX_W-1:0]])
                    nhi_next = hi_arr[end_c[IDX_W-1:0]];
                state_next = S_RESP;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (tb_reg < ta_reg)
                            res_status_next = ST_OK;
                        else if (newcnt_c > (CNT_W+1)'(MAX_RANGES))
                            res_status_next = ST_FULL;
                        else
                            state_next = S_WR;
                    end
                    CMD_CONTAINS:
                    begin
                        res_hit_next = |contain_vec;
                    end
                    CMD_NEAREST:
                    begin
                        if (used_reg == '0)
                            res_value_next = '0;
                        else if (lb_c == used_reg)
                            res_value_next = hi_arr[IDX_W'(used_reg - CNT_W'(1))];
                        else if (contain_vec[lb_c[IDX_W-1:0]])
                            res_value_next = ta_reg;
                        else if (lb_c == '0)
                            res_value_next = lo_arr[0];
                        else
                        begin
                            prev_next  = hi_arr[IDX_W'(lb_c - CNT_W'(1))];
                            near_next  = lo_arr[lb_c[IDX_W-1:0]];
                            state_next = S_NEAR;
                        end
                    end
                    CMD_READ:
                    begin
                        if ({1'b0, slot_reg} >= used_reg)
                            res_status_next = ST_INDEX;
                        else
                        begin
                            res_value_next = lo_arr[slot_reg];
                            res_end_next   = hi_arr[slot_reg];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_NEAR:
            begin
                res_value_next = (d_prev <= d_next) ? prev_reg : near_reg;
                state_next     = S_RESP;
            end
            S_WR:
            begin
                op        = (k_reg == '0) ? OP_UP : OP_WRITE;
                used_next = used_reg + CNT_W'(1) - k_reg;
                if (k_reg > CNT_W'(1))
                begin
                    dn_left_next = k_reg - CNT_W'(1);
                    state_next   = S_DN;
                end
                else
                    state_next = S_RESP;
            end
            S_DN:
            begin
                op           = OP_DN;
                dn_left_next = dn_left_reg - CNT_W'(1);
                if (dn_left_reg == CNT_W'(1))
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_hit_next    = res_hit_reg;
                    out_value_next  = res_value_reg;
                    out_end_next    = res_end_reg;
                    out_count_next  = used_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            dn_left_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            dn_left_reg   <= dn_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ta_reg         <= ta_next;
        tb_reg         <= tb_next;
        slot_reg       <= slot_next;
        lb_reg         <= lb_next;
        k_reg          <= k_next;
        nlo_reg        <= nlo_next;
        nhi_reg        <= nhi_next;
        prev_reg       <= prev_next;
        near_reg       <= near_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        res_value_reg  <= res_value_next;
        res_end_reg    <= res_end_next;
        out_status_reg <= out_status_next;
        out_hit_reg    <= out_hit_next;
        out_value_reg  <= out_value_next;
        out_end_reg    <= out_end_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.value     = out_value_reg;
    assign rsp.value_end = out_end_reg;
    assign rsp.count     = out_count_reg;

    // The set never holds more ranges than the row has cells.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_RANGES))
        else $error("range count beyond capacity");

    // The range count changes only in the write step of an add.
    a_used_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WR) |=> (used_reg == $past(used_reg)))
        else $error("range count changed outside a write");

    // Shifting down always has cycles left to run.
    a_dn_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DN) |-> (dn_left_reg != '0))
        else $error("shift sequence without remaining steps");

    // A merging cell always reaches the new start.
    a_merge_reach: assert property (@(posedge clk) disable iff (!rst_n)
        (merge_vec & ~reach_vec) == '0)
        else $error("merge flag without reach flag");

endmodule
`default_nettype wire

// File: sv/sis_cell.sv
// One cell of the range row: holds one stored range, compares it with the
// broadcast times, writes the new or merged range and takes a neighbour's
// range when the row shifts. Depends on sis_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sis_cell (
    input  wire                   clk,
    input  wire                   rst_n,
    input  sis_pkg::idx_t         idx,
    input  sis_pkg::cell_ctl_t    ctl,
    input  sis_pkg::time_t        below_lo,
    input  sis_pkg::time_t        below_hi,
    input  sis_pkg::time_t        above_lo,
    input  sis_pkg::time_t        above_hi,
    output sis_pkg::time_t        lo,
    output sis_pkg::time_t        hi,
    output sis_pkg::cell_flags_t  flags
);
    import sis_pkg::*;

    time_t       lo_reg, lo_next;
    time_t       hi_reg, hi_next;
    cell_flags_t flags_reg, flags_next;
    logic        valid;
    cnt_t        idx_w;

    assign idx_w = {1'b0, idx};
    assign valid = idx_w < ctl.used;

    // Comparisons of this range against the query times.
    always_comb
    begin
        flags_next.reach   = valid && !(hi_reg < ctl.ta);
        flags_next.merge   = flags_next.reach && !(ctl.tb < lo_reg);
        flags_next.contain = valid && !(ctl.ta < lo_reg) && !(hi_reg < ctl.ta);
    end

    // Range update: write the merged range or take a neighbour's range.
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        case (ctl.op)
            OP_WRITE:
            begin
                if (idx_w == ctl.lb)
                begin
                    lo_next = ctl.nlo;
                    hi_next = ctl.nhi;
                end
            end
            OP_UP:
            begin
                if (idx_w == ctl.lb)
                begin
                    lo_next = ctl.nlo;
                    hi_next = ctl.nhi;
                end
                else if (idx_w > ctl.lb)
                begin
                    lo_next = below_lo;
                    hi_next = below_hi;
                end
            end
            OP_DN:
            begin
                if (idx_w > ctl.lb)
                begin
                    lo_next = above_lo;
                    hi_next = above_hi;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else
            flags_reg <= flags_next;
    end

    assign lo    = lo_reg;
    assign hi    = hi_reg;
    assign flags = flags_reg;

endmodule
`default_nettype wire
